// File: hw/rtl/lsbi_pkg.sv
// ----------------------------------------------------------------------------
// lsbi_pkg
// Shared constants, types and helpers of the log scale bucket index core.
// ----------------------------------------------------------------------------
package lsbi_pkg;

   localparam int VALUE_W         = 31;
   localparam int MANT_W          = 31;
   localparam int MSB_W           = 5;
   localparam int SCALE_W         = 13;
   localparam int BUCKET_W        = 10;
   localparam int SCALE_FRAC_BITS = 8;
   localparam int BUCKET_BIAS     = 128;
   localparam int BUCKET_MAX      = 1023;
   localparam int CSR_INDEX_W     = 2;
   localparam int REQ_DATA_W      = 32;
   localparam int RSP_DATA_W      = 16;

   localparam logic [VALUE_W-1:0] MINIMUM_RESET = '0;
   localparam logic [VALUE_W-1:0] HIGHEST_RESET = VALUE_W'(1);
   localparam logic [SCALE_W-1:0] SCALE_RESET   = SCALE_W'(256);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MINIMUM = 2'd0,
      CSR_HIGHEST = 2'd1,
      CSR_SCALE   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic is_zero;
      logic at_min;
   } flag_type;

   // position of the highest set bit, 0 for a zero value
   function automatic logic [MSB_W-1:0] find_msb(input logic [VALUE_W-1:0] x);
      logic [MSB_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (x[i]) begin
            pos = MSB_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

// File: hw/rtl/lsbi_norm.sv
// ----------------------------------------------------------------------------
// lsbi_norm
// Entry stage: special-case flags, integer log and mantissa normalization.
// ----------------------------------------------------------------------------
module lsbi_norm #(
   parameter int LOG_W = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [lsbi_pkg::VALUE_W-1:0]      preference,
   input  logic [lsbi_pkg::VALUE_W-1:0]      minimum_value,
   input  logic [lsbi_pkg::VALUE_W-1:0]      highest_value,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [lsbi_pkg::MANT_W-1:0]       out_mant_p,
   output logic [lsbi_pkg::MANT_W-1:0]       out_mant_h,
   output logic [LOG_W-1:0]                  out_log_p,
   output logic [LOG_W-1:0]                  out_log_h,
   output lsbi_pkg::flag_type                out_flags
);
   import lsbi_pkg::*;

   logic                 valid_ff, valid_in;
   logic [MANT_W-1:0]    mant_p_ff, mant_p_in;
   logic [MANT_W-1:0]    mant_h_ff, mant_h_in;
   logic [LOG_W-1:0]     log_p_ff, log_p_in;
   logic [LOG_W-1:0]     log_h_ff, log_h_in;
   flag_type             flags_ff, flags_in;
   logic [VALUE_W-1:0]   high_eff;
   logic [MSB_W-1:0]     msb_p, msb_h;
   logic                 take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      high_eff         = (highest_value == '0) ? VALUE_W'(1) : highest_value;
      msb_p            = find_msb(preference);
      msb_h            = find_msb(high_eff);
      mant_p_in        = preference << (MSB_W'(MANT_W - 1) - msb_p);
      mant_h_in        = high_eff << (MSB_W'(MANT_W - 1) - msb_h);
      log_p_in         = LOG_W'(msb_p);
      log_h_in         = LOG_W'(msb_h);
      flags_in.is_zero = (preference == '0);
      flags_in.at_min  = (preference <= minimum_value);
      valid_in         = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mant_p_ff <= mant_p_in;
         mant_h_ff <= mant_h_in;
         log_p_ff  <= log_p_in;
         log_h_ff  <= log_h_in;
         flags_ff  <= flags_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_mant_p = mant_p_ff;
   assign out_mant_h = mant_h_ff;
   assign out_log_p  = log_p_ff;
   assign out_log_h  = log_h_ff;
   assign out_flags  = flags_ff;

endmodule

// File: hw/rtl/lsbi_log_cell.sv
// ----------------------------------------------------------------------------
// lsbi_log_cell
// One log2 fraction bit: squares both mantissas and shifts in the new bits.
// ----------------------------------------------------------------------------
module lsbi_log_cell #(
   parameter int LOG_W = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [lsbi_pkg::MANT_W-1:0]       in_mant_p,
   input  logic [lsbi_pkg::MANT_W-1:0]       in_mant_h,
   input  logic [LOG_W-1:0]                  in_log_p,
   input  logic [LOG_W-1:0]                  in_log_h,
   input  lsbi_pkg::flag_type                in_flags,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [lsbi_pkg::MANT_W-1:0]       out_mant_p,
   output logic [lsbi_pkg::MANT_W-1:0]       out_mant_h,
   output logic [LOG_W-1:0]                  out_log_p,
   output logic [LOG_W-1:0]                  out_log_h,
   output lsbi_pkg::flag_type                out_flags
);
   import lsbi_pkg::*;

   logic                    valid_ff, valid_in;
   logic [MANT_W-1:0]       mant_p_ff, mant_p_in;
   logic [MANT_W-1:0]       mant_h_ff, mant_h_in;
   logic [LOG_W-1:0]        log_p_ff, log_p_in;
   logic [LOG_W-1:0]        log_h_ff, log_h_in;
   flag_type                flags_ff;
   logic [2*MANT_W-1:0]     prod_p, prod_h;
   logic [MANT_W:0]         sq_p, sq_h;
   logic                    bit_p, bit_h;
   logic                    take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   always_comb begin
      prod_p    = (2*MANT_W)'(in_mant_p) * (2*MANT_W)'(in_mant_p);
      prod_h    = (2*MANT_W)'(in_mant_h) * (2*MANT_W)'(in_mant_h);
      // Q2.30 square, at or above 2.0 when the top bit is set
      sq_p      = prod_p[2*MANT_W-1:MANT_W-1];
      sq_h      = prod_h[2*MANT_W-1:MANT_W-1];
      bit_p     = sq_p[MANT_W];
      bit_h     = sq_h[MANT_W];
      mant_p_in = bit_p ? sq_p[MANT_W:1] : sq_p[MANT_W-1:0];
      mant_h_in = bit_h ? sq_h[MANT_W:1] : sq_h[MANT_W-1:0];
      log_p_in  = {in_log_p[LOG_W-2:0], bit_p};
      log_h_in  = {in_log_h[LOG_W-2:0], bit_h};
      valid_in  = take || (valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mant_p_ff <= mant_p_in;
         mant_h_ff <= mant_h_in;
         log_p_ff  <= log_p_in;
         log_h_ff  <= log_h_in;
         flags_ff  <= in_flags;
      end
   end

   assign out_valid  = valid_ff;
   assign out_mant_p = mant_p_ff;
   assign out_mant_h = mant_h_ff;
   assign out_log_p  = log_p_ff;
   assign out_log_h  = log_h_ff;
   assign out_flags  = flags_ff;

endmodule

// File: hw/rtl/lsbi_scale.sv
// ----------------------------------------------------------------------------
// lsbi_scale
// Log difference times scale, then bias, floor, clamp and output register.
// ----------------------------------------------------------------------------
module lsbi_scale #(
   parameter int LOG_FRAC_BITS = 16,
   parameter int LOG_W         = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [LOG_W-1:0]                  in_log_p,
   input  logic [LOG_W-1:0]                  in_log_h,
   input  lsbi_pkg::flag_type                in_flags,
   input  logic [lsbi_pkg::SCALE_W-1:0]      scale_factor,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [lsbi_pkg::BUCKET_W-1:0]     out_bucket
);
   import lsbi_pkg::*;

   localparam int DIFF_W    = LOG_W + 1;
   localparam int PROD_W    = SCALE_W + 1 + DIFF_W;
   localparam int TOT_W     = PROD_W + 1;
   localparam int FIX_POINT = LOG_FRAC_BITS + SCALE_FRAC_BITS;
   localparam int Q_W       = TOT_W - FIX_POINT;
   localparam logic [TOT_W-1:0] ONE_FIX  = TOT_W'(1) << FIX_POINT;
   localparam logic [TOT_W-1:0] BIAS_FIX = TOT_W'(BUCKET_BIAS) << FIX_POINT;

   logic                        mul_valid_ff, mul_valid_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   flag_type                    mul_flags_ff;
   logic signed [DIFF_W-1:0]    diff;
   logic                        mul_ready, mul_take, mul_adv;

   logic                        out_valid_ff, out_valid_in;
   logic [BUCKET_W-1:0]         bucket_ff, bucket_in;
   logic signed [TOT_W-1:0]     total;
   logic [Q_W-1:0]              q;

   assign mul_ready = !out_valid_ff || out_ready;
   assign in_ready  = !mul_valid_ff || mul_ready;
   assign mul_take  = in_valid && in_ready;
   assign mul_adv   = mul_valid_ff && mul_ready;

   always_comb begin
      diff         = $signed({1'b0, in_log_p}) - $signed({1'b0, in_log_h});
      prod_in      = PROD_W'($signed({1'b0, scale_factor})) * PROD_W'(diff);
      mul_valid_in = mul_take || (mul_valid_ff && !mul_ready);
   end

   always_comb begin
      total = TOT_W'(prod_ff) + $signed(BIAS_FIX);
      q     = total[TOT_W-1:FIX_POINT];
      if (mul_flags_ff.is_zero) begin
         bucket_in = '0;
      end else if (mul_flags_ff.at_min || (total < $signed(ONE_FIX))) begin
         bucket_in = BUCKET_W'(1);
      end else if (q > Q_W'(BUCKET_MAX)) begin
         bucket_in = BUCKET_W'(BUCKET_MAX);
      end else begin
         bucket_in = q[BUCKET_W-1:0];
      end
      out_valid_in = mul_adv || (out_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_take) begin
         prod_ff      <= prod_in;
         mul_flags_ff <= in_flags;
      end
      if (mul_adv) begin
         bucket_ff <= bucket_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_bucket = bucket_ff;

   a_zero_bucket : assert property (@(posedge clock) disable iff (reset)
      mul_adv && mul_flags_ff.is_zero |=> out_valid_ff && bucket_ff == '0)
      else $error("zero item did not give bucket zero");

   a_min_bucket : assert property (@(posedge clock) disable iff (reset)
      mul_adv && !mul_flags_ff.is_zero && mul_flags_ff.at_min
      |=> bucket_ff == BUCKET_W'(1))
      else $error("item at or below minimum did not give bucket one");

   a_nonzero_bucket : assert property (@(posedge clock) disable iff (reset)
      mul_adv && !mul_flags_ff.is_zero |=> bucket_ff != '0)
      else $error("nonzero item gave bucket zero");

   a_stage_move : assert property (@(posedge clock) disable iff (reset)
      mul_adv |=> out_valid_ff)
      else $error("item lost between multiply and output stage");

endmodule

// File: hw/rtl/log_scale_bucket_index_core.sv
// ----------------------------------------------------------------------------
// log_scale_bucket_index_core
// Logarithmic quantizer: maps a preference count to a bucket index.
// ----------------------------------------------------------------------------
//  channel  direction  ports              payload
//  req      in         req_t{valid,ready,data}  [30:0] preference
//  rsp      out        rsp_t{valid,ready,data}  [9:0]  bucket
//  csr      in         csr_{valid,ready,index,data}  register write
//
//  One item enters every cycle while the response channel does not stall.
//  Items pass the entry stage, one squaring cell per log2 fraction bit, then the scale stage.
//  Reset clears every stage valid and restores the register defaults.
//  Each stage holds while the next is full; empty slots close up on stalls.
// ----------------------------------------------------------------------------
module log_scale_bucket_index_core #(
   parameter int LOG_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [lsbi_pkg::REQ_DATA_W-1:0]       req_tdata,   // [30:0] preference
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lsbi_pkg::RSP_DATA_W-1:0]       rsp_tdata,   // [9:0] bucket
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [lsbi_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lsbi_pkg::VALUE_W-1:0]          csr_data
);
   import lsbi_pkg::*;

   localparam int LOG_W = MSB_W + LOG_FRAC_BITS;

   logic [VALUE_W-1:0]   minimum_ff, minimum_in;
   logic [VALUE_W-1:0]   highest_ff, highest_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;

   logic [LOG_FRAC_BITS:0]  stage_valid;
   logic [LOG_FRAC_BITS:0]  stage_ready;
   logic [MANT_W-1:0]       stage_mant_p [0:LOG_FRAC_BITS];
   logic [MANT_W-1:0]       stage_mant_h [0:LOG_FRAC_BITS];
   logic [LOG_W-1:0]        stage_log_p  [0:LOG_FRAC_BITS];
   logic [LOG_W-1:0]        stage_log_h  [0:LOG_FRAC_BITS];
   flag_type                stage_flags  [0:LOG_FRAC_BITS];
   logic [BUCKET_W-1:0]     bucket;

   assign csr_ready = 1'b1;

   always_comb begin
      minimum_in = minimum_ff;
      highest_in = highest_ff;
      scale_in   = scale_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MINIMUM: begin
               minimum_in = csr_data;
            end
            CSR_HIGHEST: begin
               highest_in = csr_data;
            end
            CSR_SCALE: begin
               scale_in = csr_data[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minimum_ff <= MINIMUM_RESET;
         highest_ff <= HIGHEST_RESET;
         scale_ff   <= SCALE_RESET;
      end else begin
         minimum_ff <= minimum_in;
         highest_ff <= highest_in;
         scale_ff   <= scale_in;
      end
   end

   lsbi_norm #(
      .LOG_W (LOG_W)
   ) u_norm (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .preference    (req_tdata[VALUE_W-1:0]),
      .minimum_value (minimum_ff),
      .highest_value (highest_ff),
      .out_valid     (stage_valid[0]),
      .out_ready     (stage_ready[0]),
      .out_mant_p    (stage_mant_p[0]),
      .out_mant_h    (stage_mant_h[0]),
      .out_log_p     (stage_log_p[0]),
      .out_log_h     (stage_log_h[0]),
      .out_flags     (stage_flags[0])
   );

   for (genvar g = 0; g < LOG_FRAC_BITS; g++) begin : g_cell
      lsbi_log_cell #(
         .LOG_W (LOG_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (stage_valid[g]),
         .in_ready   (stage_ready[g]),
         .in_mant_p  (stage_mant_p[g]),
         .in_mant_h  (stage_mant_h[g]),
         .in_log_p   (stage_log_p[g]),
         .in_log_h   (stage_log_h[g]),
         .in_flags   (stage_flags[g]),
         .out_valid  (stage_valid[g+1]),
         .out_ready  (stage_ready[g+1]),
         .out_mant_p (stage_mant_p[g+1]),
         .out_mant_h (stage_mant_h[g+1]),
         .out_log_p  (stage_log_p[g+1]),
         .out_log_h  (stage_log_h[g+1]),
         .out_flags  (stage_flags[g+1])
      );
   end

   lsbi_scale #(
      .LOG_FRAC_BITS (LOG_FRAC_BITS),
      .LOG_W         (LOG_W)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stage_valid[LOG_FRAC_BITS]),
      .in_ready     (stage_ready[LOG_FRAC_BITS]),
      .in_log_p     (stage_log_p[LOG_FRAC_BITS]),
      .in_log_h     (stage_log_h[LOG_FRAC_BITS]),
      .in_flags     (stage_flags[LOG_FRAC_BITS]),
      .scale_factor (scale_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_bucket   (bucket)
   );

   // final mantissas are not needed past the last cell
   logic unused_mant;
   assign unused_mant = ^{stage_mant_p[LOG_FRAC_BITS], stage_mant_h[LOG_FRAC_BITS],
                          req_tdata[REQ_DATA_W-1:VALUE_W]};

   assign rsp_tdata = RSP_DATA_W'(bucket);

endmodule
